>>> rtl/cst_pkg.sv
// Shared types, token kind codes, character classes and helper functions
// for the C-subset token scanner. Depends on nothing; all other files import it.
package cst_pkg;

  // Widths of counters and buffers.
  localparam int POS_BITS       = 24;
  localparam int LINE_BITS      = 16;
  localparam int WORD_BUF_CHARS = 8;
  localparam int WB_IDX_W       = $clog2(WORD_BUF_CHARS);
  localparam int WLEN_W         = 4;
  localparam logic [WLEN_W-1:0] WLEN_MAX = '1;
  localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

  // One item can decide at most three tokens.
  localparam int RES_SLOTS = 3;
  localparam int CNT_W     = 2;

  // Output word layout, lowest bits first.
  localparam int KIND_W     = 6;
  localparam int KIND_LSB   = 0;
  localparam int START_LSB  = KIND_LSB + KIND_W;
  localparam int END_LSB    = START_LSB + POS_BITS;
  localparam int LINE_LSB   = END_LSB + POS_BITS;
  localparam int COL_LSB    = LINE_LSB + LINE_BITS;
  localparam int OUT_BITS   = COL_LSB + LINE_BITS;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_NONE        = 6'd0;
  localparam logic [KIND_W-1:0] KIND_EOF         = 6'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT       = 6'd1;
  localparam logic [KIND_W-1:0] KIND_KW_FIRST    = 6'd2;
  localparam logic [KIND_W-1:0] KIND_INTNUM      = 6'd12;
  localparam logic [KIND_W-1:0] KIND_FLOATNUM    = 6'd13;
  localparam logic [KIND_W-1:0] KIND_STRING      = 6'd14;
  localparam logic [KIND_W-1:0] KIND_CHARLIT     = 6'd15;
  localparam logic [KIND_W-1:0] KIND_LPAREN      = 6'd16;
  localparam logic [KIND_W-1:0] KIND_RPAREN      = 6'd17;
  localparam logic [KIND_W-1:0] KIND_LBRACE      = 6'd18;
  localparam logic [KIND_W-1:0] KIND_RBRACE      = 6'd19;
  localparam logic [KIND_W-1:0] KIND_LBRACKET    = 6'd20;
  localparam logic [KIND_W-1:0] KIND_RBRACKET    = 6'd21;
  localparam logic [KIND_W-1:0] KIND_SEMI        = 6'd22;
  localparam logic [KIND_W-1:0] KIND_COMMA       = 6'd23;
  localparam logic [KIND_W-1:0] KIND_HASH        = 6'd24;
  localparam logic [KIND_W-1:0] KIND_ASSIGN      = 6'd25;
  localparam logic [KIND_W-1:0] KIND_EQ          = 6'd26;
  localparam logic [KIND_W-1:0] KIND_NOT         = 6'd27;
  localparam logic [KIND_W-1:0] KIND_NE          = 6'd28;
  localparam logic [KIND_W-1:0] KIND_LT          = 6'd29;
  localparam logic [KIND_W-1:0] KIND_LE          = 6'd30;
  localparam logic [KIND_W-1:0] KIND_GT          = 6'd31;
  localparam logic [KIND_W-1:0] KIND_GE          = 6'd32;
  localparam logic [KIND_W-1:0] KIND_MUL         = 6'd33;
  localparam logic [KIND_W-1:0] KIND_MUL_ASSIGN  = 6'd34;
  localparam logic [KIND_W-1:0] KIND_DIV         = 6'd35;
  localparam logic [KIND_W-1:0] KIND_DIV_ASSIGN  = 6'd36;
  localparam logic [KIND_W-1:0] KIND_AMP         = 6'd37;
  localparam logic [KIND_W-1:0] KIND_LAND        = 6'd38;
  localparam logic [KIND_W-1:0] KIND_PIPE        = 6'd39;
  localparam logic [KIND_W-1:0] KIND_LOR         = 6'd40;
  localparam logic [KIND_W-1:0] KIND_PLUS        = 6'd41;
  localparam logic [KIND_W-1:0] KIND_INC         = 6'd42;
  localparam logic [KIND_W-1:0] KIND_ADD_ASSIGN  = 6'd43;
  localparam logic [KIND_W-1:0] KIND_MINUS       = 6'd44;
  localparam logic [KIND_W-1:0] KIND_DEC         = 6'd45;
  localparam logic [KIND_W-1:0] KIND_SUB_ASSIGN  = 6'd46;
  localparam logic [KIND_W-1:0] KIND_ERROR       = 6'd47;

  // Character codes used by name.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  // Keyword table; text is right-justified, so character i of keyword k
  // sits at byte (KW_LEN[k]-1-i) from the bottom.
  localparam int KW_COUNT   = 10;
  localparam int KW_MAX_LEN = 7;
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    "int", "float", "char", "return", "const",
    "for", "while", "if", "else", "include"
  };
  localparam logic [WLEN_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd4, 4'd6, 4'd5, 4'd3, 4'd5, 4'd2, 4'd4, 4'd7
  };

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_IDENT, MODE_INT, MODE_INT_DOT,
    MODE_FLOAT, MODE_STR, MODE_CHR, MODE_OP
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t           mode;
    logic [POS_BITS-1:0]  token_start;
    logic [POS_BITS-1:0]  byte_pos;
    logic [LINE_BITS-1:0] line_count;
    logic [LINE_BITS-1:0] col_count;
    logic [WLEN_W-1:0]    word_len;
    logic [7:0]           pending;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    mode:        MODE_IDLE,
    token_start: '0,
    byte_pos:    '0,
    line_count:  LINE_ONE,
    col_count:   LINE_ONE,
    word_len:    '0,
    pending:     '0
  };

  typedef logic [WORD_BUF_CHARS-1:0][7:0] word_buf_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [POS_BITS-1:0]  start_pos;
    logic [POS_BITS-1:0]  end_pos;
    logic [LINE_BITS-1:0] line_no;
    logic [LINE_BITS-1:0] col_no;
    logic                 last;
  } token_t;

  typedef token_t [RES_SLOTS-1:0] token_slots_t;

  typedef struct packed {
    scan_state_t       st;
    logic              emit;
    logic [KIND_W-1:0] kind;
  } fresh_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  // Punctuation that is a token by itself, KIND_NONE otherwise.
  function automatic logic [KIND_W-1:0] single_kind(logic [7:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      "[":     k = KIND_LBRACKET;
      "]":     k = KIND_RBRACKET;
      ";":     k = KIND_SEMI;
      ",":     k = KIND_COMMA;
      "#":     k = KIND_HASH;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Operator that may take a second character, KIND_NONE otherwise.
  function automatic logic [KIND_W-1:0] op_base(logic [7:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      "=":     k = KIND_ASSIGN;
      "!":     k = KIND_NOT;
      "<":     k = KIND_LT;
      ">":     k = KIND_GT;
      "*":     k = KIND_MUL;
      "/":     k = KIND_DIV;
      "&":     k = KIND_AMP;
      "|":     k = KIND_PIPE;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Two-character operator formed by first and c, KIND_NONE if they do not pair.
  function automatic logic [KIND_W-1:0] op_pair(logic [7:0] first, logic [7:0] c);
    logic [KIND_W-1:0] k;
    k = KIND_NONE;
    unique case (first)
      "=":     if (c == "=") k = KIND_EQ;
      "!":     if (c == "=") k = KIND_NE;
      "<":     if (c == "=") k = KIND_LE;
      ">":     if (c == "=") k = KIND_GE;
      "*":     if (c == "=") k = KIND_MUL_ASSIGN;
      "/":     if (c == "=") k = KIND_DIV_ASSIGN;
      "&":     if (c == "&") k = KIND_LAND;
      "|":     if (c == "|") k = KIND_LOR;
      "+": begin
        if (c == "+")      k = KIND_INC;
        else if (c == "=") k = KIND_ADD_ASSIGN;
      end
      "-": begin
        if (c == "-")      k = KIND_DEC;
        else if (c == "=") k = KIND_SUB_ASSIGN;
      end
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Advance offset, line and column past one byte, all saturating.
  function automatic scan_state_t consume(scan_state_t s, logic [7:0] c);
    scan_state_t r;
    r = s;
    if (!(&s.byte_pos)) r.byte_pos = s.byte_pos + 1'b1;
    if (c == CH_LF) begin
      if (!(&s.line_count)) r.line_count = s.line_count + 1'b1;
      r.col_count = LINE_ONE;
    end else if (!(&s.col_count)) begin
      r.col_count = s.col_count + 1'b1;
    end
    return r;
  endfunction

  // Start scanning at byte c; a one-byte token is reported at once.
  function automatic fresh_t fresh(scan_state_t s, logic [7:0] c);
    fresh_t            f;
    logic [KIND_W-1:0] ks;
    ks = single_kind(c);
    f.st = s;
    f.st.token_start = s.byte_pos;
    f.st.mode = MODE_IDLE;
    f.st = consume(f.st, c);
    f.emit = 1'b0;
    f.kind = KIND_ERROR;
    if (!is_blank(c)) begin
      priority if (is_alpha(c)) begin
        f.st.word_len = {{(WLEN_W-1){1'b0}}, 1'b1};
        f.st.mode = MODE_IDENT;
      end else if (is_digit(c)) begin
        f.st.mode = MODE_INT;
      end else if (c == CH_DQUOTE) begin
        f.st.mode = MODE_STR;
      end else if (c == CH_SQUOTE) begin
        f.st.mode = MODE_CHR;
      end else if (ks != KIND_NONE) begin
        f.emit = 1'b1;
        f.kind = ks;
      end else if (op_base(c) != KIND_NONE) begin
        f.st.pending = c;
        f.st.mode = MODE_OP;
      end else begin
        f.emit = 1'b1;
        f.kind = KIND_ERROR;
      end
    end
    return f;
  endfunction

  // Identifier or keyword, from the buffered leading characters.
  function automatic logic [KIND_W-1:0] word_kind(logic [WLEN_W-1:0] len, word_buf_t wb);
    logic [KIND_W-1:0] k;
    logic              hit;
    k = KIND_IDENT;
    for (int kw = KW_COUNT - 1; kw >= 0; kw--) begin
      hit = (len == KW_LEN[kw]);
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (i < int'(KW_LEN[kw]) &&
            wb[i] != KW_TEXT[kw][(int'(KW_LEN[kw]) - 1 - i) * 8 +: 8]) hit = 1'b0;
      end
      if (hit) k = KIND_KW_FIRST + KIND_W'(kw);
    end
    return k;
  endfunction

  function automatic token_t make_tok(scan_state_t s, logic [KIND_W-1:0] k);
    token_t t;
    t.kind      = k;
    t.start_pos = s.token_start;
    t.end_pos   = s.byte_pos;
    t.line_no   = s.line_count;
    t.col_no    = s.col_count;
    t.last      = 1'b0;
    return t;
  endfunction

endpackage

>>> rtl/cst_step.sv
// One scanner step: from the current scan state, word buffer and one input
// byte, the next state and the up to three tokens decided. Uses cst_pkg.
module cst_step (
  input  cst_pkg::scan_state_t  st_i,
  input  cst_pkg::word_buf_t    wb_i,
  input  logic [7:0]            ch_i,
  input  logic                  end_i,
  output cst_pkg::scan_state_t  st_o,
  output cst_pkg::word_buf_t    wb_o,
  output cst_pkg::token_slots_t toks_o,
  output logic [cst_pkg::CNT_W-1:0] n_o
);
  import cst_pkg::*;

  always_comb begin
    scan_state_t       st;
    word_buf_t         wb;
    token_slots_t      toks;
    logic [CNT_W-1:0]  n;
    logic              do_flush;
    logic              do_fresh;
    logic [KIND_W-1:0] kp;
    logic [KIND_W-1:0] kf;
    fresh_t            f;

    st       = st_i;
    wb       = wb_i;
    toks     = '0;
    n        = '0;
    do_flush = 1'b0;
    do_fresh = 1'b0;
    kf       = KIND_NONE;
    f        = '0;
    kp       = op_pair(st_i.pending, ch_i);

    // First phase: extend the open token or decide to close it.
    if (end_i) begin
      do_flush = 1'b1;
    end else begin
      unique case (st_i.mode)
        MODE_IDENT: begin
          if (is_alpha(ch_i) || is_digit(ch_i) || ch_i == CH_USCORE) begin
            st = consume(st, ch_i);
            if (int'(st_i.word_len) < WORD_BUF_CHARS)
              wb[st_i.word_len[WB_IDX_W-1:0]] = ch_i;
            if (st_i.word_len != WLEN_MAX) st.word_len = st_i.word_len + 1'b1;
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(ch_i)) begin
            st = consume(st, ch_i);
          end else if (ch_i == CH_DOT) begin
            st.pending = CH_DOT;
            st.mode = MODE_INT_DOT;
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        MODE_INT_DOT: begin
          if (is_digit(ch_i)) begin
            st = consume(st, CH_DOT);
            st = consume(st, ch_i);
            st.mode = MODE_FLOAT;
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        MODE_FLOAT: begin
          if (is_digit(ch_i)) begin
            st = consume(st, ch_i);
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        MODE_STR, MODE_CHR: begin
          st = consume(st, ch_i);
          if (ch_i == ((st_i.mode == MODE_STR) ? CH_DQUOTE : CH_SQUOTE)) do_flush = 1'b1;
        end
        MODE_OP: begin
          if (kp != KIND_NONE) begin
            st = consume(st, ch_i);
            toks[n] = make_tok(st, kp);
            n = n + 1'b1;
            st.mode = MODE_IDLE;
          end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
          end
        end
        MODE_IDLE: begin
          do_fresh = 1'b1;
        end
        default: begin
          do_fresh = 1'b1;
        end
      endcase
    end

    // Second phase: report the token left open by the mode.
    if (do_flush) begin
      unique case (st.mode)
        MODE_IDENT:   kf = word_kind(st.word_len, wb_i);
        MODE_INT:     kf = KIND_INTNUM;
        MODE_INT_DOT: kf = KIND_INTNUM;
        MODE_FLOAT:   kf = KIND_FLOATNUM;
        MODE_STR:     kf = KIND_STRING;
        MODE_CHR:     kf = KIND_CHARLIT;
        MODE_OP:      kf = op_base(st.pending);
        default:      kf = KIND_NONE;
      endcase
      if (st.mode != MODE_IDLE) begin
        toks[n] = make_tok(st, kf);
        n = n + 1'b1;
      end
      // A held dot that did not start a fraction is scanned on its own.
      if (st.mode == MODE_INT_DOT) begin
        f = fresh(st, st.pending);
        st = f.st;
        if (f.emit) begin
          toks[n] = make_tok(st, f.kind);
          n = n + 1'b1;
        end
      end
      st.mode = MODE_IDLE;
    end

    // Third phase: the current byte starts a new token.
    if (do_fresh) begin
      f = fresh(st, ch_i);
      st = f.st;
      if (is_alpha(ch_i)) wb[0] = ch_i;
      if (f.emit) begin
        toks[n] = make_tok(st, f.kind);
        n = n + 1'b1;
      end
    end

    // End of source: end-of-file token, then back to the start state.
    if (end_i) begin
      st.token_start = st.byte_pos;
      toks[n] = make_tok(st, KIND_EOF);
      n = n + 1'b1;
      st = SCAN_RESET;
    end

    if (n != '0) toks[n - 1'b1].last = 1'b1;

    st_o   = st;
    wb_o   = wb;
    toks_o = toks;
    n_o    = n;
  end

endmodule

>>> rtl/c_subset_token_scanner.sv
// A token decided by an input word reaches out_* through the input register, then
// the scan step into the result queue, whose slot 0 drives the output.
// Throughput: one input word per cycle while each word yields at most one token and
// the receiver takes each token; a word that yields more (up to three) holds the input,
// paced by the single output port draining the result queue. Reset is synchronous and
// active low: scan state returns to offset 0, line 1, column 1; the word buffer is not cleared.
module c_subset_token_scanner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] ch
  input  logic                           in_tuser,   // end_flag
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [5:0] kind, [29:6] start_pos, [53:30] end_pos, [69:54] line_no,
  // [85:70] col_no, [87:86] zero
  output logic [cst_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast   // last
);
  import cst_pkg::*;

  // Input register: one word waiting for the scan step.
  logic       in_v_r;
  logic [7:0] in_ch_r;
  logic       in_end_r;

  // Scan state and the leading characters of the current identifier.
  scan_state_t st_r;
  scan_state_t st_nxt;
  word_buf_t   wb_r;
  word_buf_t   wb_nxt;

  // Result queue: slot 0 drives the output; the rest shift down as words leave.
  token_t       tok_r [RES_SLOTS];
  token_t       tok_nxt [RES_SLOTS];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  token_slots_t     step_toks;
  logic [CNT_W-1:0] step_n;

  logic q_ready;
  logic step_go;
  logic pop;

  cst_step u_step (
    .st_i   (st_r),
    .wb_i   (wb_r),
    .ch_i   (in_ch_r),
    .end_i  (in_end_r),
    .st_o   (st_nxt),
    .wb_o   (wb_nxt),
    .toks_o (step_toks),
    .n_o    (step_n)
  );

  // The queue can take a new batch when it is empty or its last word leaves now.
  assign pop     = out_tvalid && out_tready;
  assign q_ready = (cnt_r == '0) || (cnt_r == CNT_W'(1) && out_tready);
  assign step_go = in_v_r && q_ready;
  assign in_tready = !in_v_r || q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_ch_r  <= in_tdata;
      in_end_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SCAN_RESET;
    end else if (step_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      wb_r <= wb_nxt;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < RES_SLOTS; i++) tok_nxt[i] = tok_r[i];
    if (step_go) begin
      cnt_nxt = step_n;
      for (int i = 0; i < RES_SLOTS; i++) tok_nxt[i] = step_toks[i];
    end else if (pop) begin
      cnt_nxt = cnt_r - 1'b1;
      for (int i = 0; i < RES_SLOTS - 1; i++) tok_nxt[i] = tok_r[i + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_SLOTS; i++) tok_r[i] <= tok_nxt[i];
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = tok_r[0].last;

  always_comb begin
    out_tdata = '0;
    out_tdata[KIND_LSB  +: KIND_W]    = tok_r[0].kind;
    out_tdata[START_LSB +: POS_BITS]  = tok_r[0].start_pos;
    out_tdata[END_LSB   +: POS_BITS]  = tok_r[0].end_pos;
    out_tdata[LINE_LSB  +: LINE_BITS] = tok_r[0].line_no;
    out_tdata[COL_LSB   +: LINE_BITS] = tok_r[0].col_no;
  end

endmodule

>>> rtl/cst_checker.sv
// Port-level checks on the token output of the scanner, and the bind that
// attaches them to c_subset_token_scanner. Uses cst_pkg for the word layout.
module cst_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [cst_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);
  import cst_pkg::*;

  logic [KIND_W-1:0]    kind;
  logic [POS_BITS-1:0]  start_pos;
  logic [POS_BITS-1:0]  end_pos;
  logic [LINE_BITS-1:0] line_no;
  logic [LINE_BITS-1:0] col_no;

  assign kind      = out_tdata[KIND_LSB  +: KIND_W];
  assign start_pos = out_tdata[START_LSB +: POS_BITS];
  assign end_pos   = out_tdata[END_LSB   +: POS_BITS];
  assign line_no   = out_tdata[LINE_LSB  +: LINE_BITS];
  assign col_no    = out_tdata[COL_LSB   +: LINE_BITS];

  // A stalled word stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word withdrawn while stalled");

  // A stalled word keeps its contents.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // A token never ends before it starts.
  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> start_pos <= end_pos)
    else $error("token end offset below start offset");

  // Line and column counters start at one and saturate, so they are never zero.
  a_line_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> line_no != '0 && col_no != '0)
    else $error("line or column of zero reported");

  // End of file is the final token of its word and covers no bytes.
  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && kind == KIND_EOF |-> out_tlast && start_pos == end_pos)
    else $error("malformed end-of-file token");

endmodule

bind c_subset_token_scanner cst_checker u_cst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> tb/c_subset_token_scanner_test.sv
// Self-checking testbench for the C-subset token scanner: feeds source words, predicts
// every token in its own scanner model and checks each result word field by field.
// Depends on cst_pkg (kind codes, scan modes, token layout) and c_subset_token_scanner.
`timescale 1ns / 100ps

module c_subset_token_scanner_test;
  import cst_pkg::*;

  // Least number of random source words before the closing end-of-source word.
  localparam int RANDOM_WORDS = 235;
  // Cycles in which no word moves on either side before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  // Cycles allowed after the last expected token for stray output to show up.
  localparam int DRAIN_CYCLES = 16;
  // Cycles the receiver refuses output once, so that the result queue backs up.
  localparam int BACKLOG_CYCLES = 100;
  // Cap on the tokens kept for one source word; a word decides at most three.
  localparam int MAX_TOKENS = 4;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;     // [7:0] ch
  logic                  in_tuser = 1'b0;   // end_flag
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [5:0] kind, [29:6] start_pos, [53:30] end_pos, [69:54] line_no, [85:70] col_no
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;         // last

  always #10 clk = ~clk;

  c_subset_token_scanner uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // Scanner model. It mirrors the scan state of the block: the open token's
  // mode, where it started, the running offset, line and column, the first
  // characters of an identifier and the operator byte waiting for a partner.
  // ---------------------------------------------------------------------------
  scan_mode_t           lex_mode;
  logic [POS_BITS-1:0]  lex_first;
  logic [POS_BITS-1:0]  lex_pos;
  logic [LINE_BITS-1:0] lex_line;
  logic [LINE_BITS-1:0] lex_col;
  logic [7:0]           lex_word [WORD_BUF_CHARS];
  logic [3:0]           lex_wlen;
  logic [7:0]           lex_held;

  // Tokens decided by the word being modeled, and all tokens still owed by the block.
  token_t step_tokens [$];
  token_t lexed_tokens [$];

  string reserved_words [KW_COUNT] = '{
    "int", "float", "char", "return", "const",
    "for", "while", "if", "else", "include"
  };

  int fault_count = 0;

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Kind of a punctuation or operator byte standing alone, KIND_NONE for anything else.
  function automatic logic [KIND_W-1:0] sign_kind(input logic [7:0] c);
    case (c)
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      "{":     return KIND_LBRACE;
      "}":     return KIND_RBRACE;
      "[":     return KIND_LBRACKET;
      "]":     return KIND_RBRACKET;
      ";":     return KIND_SEMI;
      ",":     return KIND_COMMA;
      "#":     return KIND_HASH;
      "=":     return KIND_ASSIGN;
      "!":     return KIND_NOT;
      "<":     return KIND_LT;
      ">":     return KIND_GT;
      "*":     return KIND_MUL;
      "/":     return KIND_DIV;
      "&":     return KIND_AMP;
      "|":     return KIND_PIPE;
      "+":     return KIND_PLUS;
      "-":     return KIND_MINUS;
      default: return KIND_NONE;
    endcase
  endfunction

  // Operator bytes that must wait for the next byte before they are decided.
  function automatic bit may_pair(input logic [7:0] c);
    return c inside {"=", "!", "<", ">", "*", "/", "&", "|", "+", "-"};
  endfunction

  // Two-byte operator kind; the codes of the paired forms follow the single one.
  function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] first,
                                                  input logic [7:0] c);
    logic [KIND_W-1:0] base;
    base = sign_kind(first);
    if (first == "&" || first == "|") return (c == first) ? base + 6'd1 : KIND_NONE;
    if (first == "+" || first == "-") begin
      if (c == first) return base + 6'd1;
      return (c == "=") ? base + 6'd2 : KIND_NONE;
    end
    return (c == "=") ? base + 6'd1 : KIND_NONE;
  endfunction

  // Keyword compare over the buffered characters; longer words are identifiers.
  function automatic logic [KIND_W-1:0] lookup_word();
    logic [KIND_W-1:0] k;
    bit                same;
    k = KIND_IDENT;
    for (int n = 0; n < KW_COUNT; n++) begin
      if (int'(lex_wlen) == reserved_words[n].len() &&
          reserved_words[n].len() <= WORD_BUF_CHARS) begin
        same = 1'b1;
        for (int i = 0; i < reserved_words[n].len(); i++)
          if (lex_word[i] != reserved_words[n][i]) same = 1'b0;
        if (same) k = KIND_KW_FIRST + KIND_W'(n);
      end
    end
    return k;
  endfunction

  task automatic clear_scan();
    lex_mode  = MODE_IDLE;
    lex_first = '0;
    lex_pos   = '0;
    lex_line  = LINE_ONE;
    lex_col   = LINE_ONE;
    lex_wlen  = '0;
    lex_held  = '0;
  endtask

  // Step offset, line and column past one byte; all three stop at their maximum.
  task automatic advance(input logic [7:0] c);
    if (lex_pos != '1) lex_pos = lex_pos + 1'b1;
    if (c == CH_LF) begin
      if (lex_line != '1) lex_line = lex_line + 1'b1;
      lex_col = LINE_ONE;
    end else if (lex_col != '1) begin
      lex_col = lex_col + 1'b1;
    end
  endtask

  task automatic note_token(input logic [KIND_W-1:0] k);
    token_t t;
    t.kind      = k;
    t.start_pos = lex_first;
    t.end_pos   = lex_pos;
    t.line_no   = lex_line;
    t.col_no    = lex_col;
    t.last      = 1'b0;
    if (step_tokens.size() < MAX_TOKENS) step_tokens = {step_tokens, t};
  endtask

  // Begin a new token at byte c; single punctuation and unknown bytes are decided here.
  task automatic start_token(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    k = sign_kind(c);
    lex_first = lex_pos;
    lex_mode  = MODE_IDLE;
    advance(c);
    if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) return;
    if (is_letter(c)) begin
      lex_word[0] = c;
      lex_wlen    = 4'd1;
      lex_mode    = MODE_IDENT;
    end else if (is_num(c)) begin
      lex_mode = MODE_INT;
    end else if (c == CH_DQUOTE) begin
      lex_mode = MODE_STR;
    end else if (c == CH_SQUOTE) begin
      lex_mode = MODE_CHR;
    end else if (k != KIND_NONE && !may_pair(c)) begin
      note_token(k);
    end else if (k != KIND_NONE) begin
      lex_held = c;
      lex_mode = MODE_OP;
    end else begin
      note_token(KIND_ERROR);
    end
  endtask

  // Close whatever token is open. A held dot after an integer becomes an error token.
  task automatic close_open();
    case (lex_mode)
      MODE_IDENT: note_token(lookup_word());
      MODE_INT:   note_token(KIND_INTNUM);
      MODE_INT_DOT: begin
        note_token(KIND_INTNUM);
        start_token(lex_held);
      end
      MODE_FLOAT: note_token(KIND_FLOATNUM);
      MODE_STR:   note_token(KIND_STRING);
      MODE_CHR:   note_token(KIND_CHARLIT);
      MODE_OP:    note_token(sign_kind(lex_held));
      default: ;
    endcase
    lex_mode = MODE_IDLE;
  endtask

  // Model one accepted source word; the tokens it decides land in step_tokens.
  task automatic lex_item(input logic [7:0] c, input logic eos);
    logic [KIND_W-1:0] pk;
    step_tokens.delete();
    if (eos) begin
      close_open();
      lex_first = lex_pos;
      note_token(KIND_EOF);
      clear_scan();
    end else begin
      case (lex_mode)
        MODE_IDENT: begin
          if (is_letter(c) || is_num(c) || c == CH_USCORE) begin
            advance(c);
            if (lex_wlen < WORD_BUF_CHARS) lex_word[lex_wlen[WB_IDX_W-1:0]] = c;
            if (lex_wlen != 4'hF) lex_wlen = lex_wlen + 1'b1;
          end else begin
            close_open();
            start_token(c);
          end
        end
        MODE_INT: begin
          if (is_num(c)) begin
            advance(c);
          end else if (c == CH_DOT) begin
            lex_held = CH_DOT;
            lex_mode = MODE_INT_DOT;
          end else begin
            close_open();
            start_token(c);
          end
        end
        MODE_INT_DOT: begin
          if (is_num(c)) begin
            advance(CH_DOT);
            advance(c);
            lex_mode = MODE_FLOAT;
          end else begin
            close_open();
            start_token(c);
          end
        end
        MODE_FLOAT: begin
          if (is_num(c)) begin
            advance(c);
          end else begin
            close_open();
            start_token(c);
          end
        end
        MODE_STR, MODE_CHR: begin
          advance(c);
          if (c == ((lex_mode == MODE_STR) ? CH_DQUOTE : CH_SQUOTE)) close_open();
        end
        MODE_OP: begin
          pk = pair_kind(lex_held, c);
          if (pk != KIND_NONE) begin
            advance(c);
            note_token(pk);
            lex_mode = MODE_IDLE;
          end else begin
            close_open();
            start_token(c);
          end
        end
        default: start_token(c);
      endcase
    end
    if (step_tokens.size() > 0) step_tokens[$].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Directed script. The first row, right after reset, and the unknown-byte
  // rows carry their token typed in; the rest use the model.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       typed;
    token_t     tok;
  } script_row_t;

  localparam script_row_t SCRIPT [25] = '{
    // End of source on an empty source: eof at offset 0, line 1, column 1.
    '{8'h00,     1'b1, 1'b1, '{KIND_EOF,   24'd0, 24'd0, 16'd1, 16'd1, 1'b1}},
    // Top and bottom byte values are both unknown characters.
    '{8'hFF,     1'b0, 1'b1, '{KIND_ERROR, 24'd0, 24'd1, 16'd1, 16'd2, 1'b1}},
    '{8'h00,     1'b0, 1'b1, '{KIND_ERROR, 24'd1, 24'd2, 16'd1, 16'd3, 1'b1}},
    // Integer, dot, letter: integer, then the dot as an error, then an identifier.
    '{"1",       1'b0, 1'b0, '0},
    '{CH_DOT,    1'b0, 1'b0, '0},
    '{"x",       1'b0, 1'b0, '0},
    '{CH_SPACE,  1'b0, 1'b0, '0},
    // A string holding a newline, left open at end of source.
    '{CH_DQUOTE, 1'b0, 1'b0, '0},
    '{"a",       1'b0, 1'b0, '0},
    '{CH_LF,     1'b0, 1'b0, '0},
    '{8'h00,     1'b1, 1'b0, '0},
    // Integer and dot pending at end of source: three tokens from one word.
    '{"1",       1'b0, 1'b0, '0},
    '{CH_DOT,    1'b0, 1'b0, '0},
    '{8'h5A,     1'b1, 1'b0, '0},
    // An open character literal at end of source.
    '{CH_SQUOTE, 1'b0, 1'b0, '0},
    '{8'h00,     1'b1, 1'b0, '0},
    // Identifier, compound assignment, decimal number, tab and carriage return blanks.
    '{"a",       1'b0, 1'b0, '0},
    '{"+",       1'b0, 1'b0, '0},
    '{"=",       1'b0, 1'b0, '0},
    '{CH_TAB,    1'b0, 1'b0, '0},
    '{"9",       1'b0, 1'b0, '0},
    '{CH_DOT,    1'b0, 1'b0, '0},
    '{"5",       1'b0, 1'b0, '0},
    '{CH_CR,     1'b0, 1'b0, '0},
    '{8'hFF,     1'b1, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Random source text: mostly well-formed lexemes with random content, some
  // noise bytes, open literals and ends of source. Each entry is {eos, ch}.
  // ---------------------------------------------------------------------------
  logic [8:0] source_text [$];

  task automatic put(input logic [7:0] c);
    source_text = {source_text, {1'b0, c}};
  endtask

  // The byte that travels with an end-of-source word is random; the block must ignore it.
  task automatic put_end();
    source_text = {source_text, {1'b1, 8'($urandom_range(0, 255))}};
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return rand_letter();
    if (r < 9) return rand_digit();
    return CH_USCORE;
  endfunction

  task automatic add_lexeme();
    int         pick;
    string      w;
    string      signs;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // Keyword, sometimes with one more character so it turns into an identifier.
      w = reserved_words[$urandom_range(0, KW_COUNT - 1)];
      foreach (w[i]) put(w[i]);
      if ($urandom_range(0, 3) == 0) put(rand_word_char());
    end else if (pick < 24) begin
      // Identifier; long ones run past the buffered prefix.
      put(rand_letter());
      repeat ($urandom_range(0, ($urandom_range(0, 4) == 0) ? 18 : 5)) put(rand_word_char());
    end else if (pick < 33) begin
      repeat ($urandom_range(1, 4)) put(rand_digit());
    end else if (pick < 41) begin
      repeat ($urandom_range(1, 3)) put(rand_digit());
      put(CH_DOT);
      repeat ($urandom_range(1, 3)) put(rand_digit());
    end else if (pick < 46) begin
      // Integer and dot; whatever follows decides whether it becomes a decimal.
      repeat ($urandom_range(1, 2)) put(rand_digit());
      put(CH_DOT);
    end else if (pick < 54) begin
      put(CH_DQUOTE);
      repeat ($urandom_range(0, 6)) begin
        c = 8'($urandom_range(0, 255));
        put((c == CH_DQUOTE) ? CH_LF : c);
      end
      if ($urandom_range(0, 9) != 0) put(CH_DQUOTE);
    end else if (pick < 59) begin
      put(CH_SQUOTE);
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : rand_letter();
      put((c == CH_SQUOTE) ? CH_SPACE : c);
      if ($urandom_range(0, 9) != 0) put(CH_SQUOTE);
    end else if (pick < 70) begin
      signs = "(){}[];,#";
      put(signs[$urandom_range(0, signs.len() - 1)]);
    end else if (pick < 87) begin
      // Operator byte, often followed by a byte that may pair with it.
      signs = "=!<>*/&|+-";
      put(signs[$urandom_range(0, signs.len() - 1)]);
      if ($urandom_range(0, 4) < 3) begin
        signs = "=&|+-";
        put(signs[$urandom_range(0, signs.len() - 1)]);
      end
    end else if (pick < 95) begin
      put(8'($urandom_range(0, 255)));
    end else begin
      put_end();
    end
    // Blanks between lexemes, of every sort, some of the time.
    if ($urandom_range(0, 1) == 0) begin
      signs = " \t\r\n";
      repeat ($urandom_range(1, 2)) put(signs[$urandom_range(0, 3)]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idle gaps: most short, some long; the sender also has calm stretches.
  // ---------------------------------------------------------------------------
  bit random_phase = 1'b0;
  bit draining_blocked = 1'b0;
  bit backlog_done = 1'b0;
  int calm_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Offer one source word and wait for the handshake. On acceptance the model
  // runs, and either its tokens or the typed-in token are added to what is owed.
  task automatic offer(input logic [8:0] item, input logic typed, input token_t tok);
    int gap;
    if (draining_blocked) begin
      gap = 0;
    end else if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(10, 30);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item[7:0];
    in_tuser  <= item[8];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_item(item[7:0], item[8]);
    if (typed) begin
      lexed_tokens = {lexed_tokens, tok};
    end else begin
      foreach (step_tokens[i]) lexed_tokens = {lexed_tokens, step_tokens[i]};
    end
  endtask

  // Receiver. Once, early in the random part, it refuses output for a long
  // stretch while the sender keeps offering words back to back, so the block
  // fills its result queue and must hold off its input.
  initial begin : receiver
    int run;
    int stall;
    @(posedge clk);
    forever begin
      if (random_phase && !backlog_done) begin
        backlog_done     = 1'b1;
        draining_blocked = 1'b1;
        out_tready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(posedge clk);
        draining_blocked = 1'b0;
      end else begin
        out_tready <= 1'b1;
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
        repeat (run) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted result word against the oldest owed token.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin : take_token
    token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (lexed_tokens.size() == 0) begin
        $display("%0t ns: token expected none, got kind %0d at %0d..%0d", $time,
                 out_tdata[KIND_LSB +: KIND_W], out_tdata[START_LSB +: POS_BITS],
                 out_tdata[END_LSB +: POS_BITS]);
        fault_count++;
      end else begin
        want = lexed_tokens.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_tdata[KIND_LSB +: KIND_W]));
        check_field("start_pos", 32'(want.start_pos), 32'(out_tdata[START_LSB +: POS_BITS]));
        check_field("end_pos", 32'(want.end_pos), 32'(out_tdata[END_LSB +: POS_BITS]));
        check_field("line_no", 32'(want.line_no), 32'(out_tdata[LINE_LSB +: LINE_BITS]));
        check_field("col_no", 32'(want.col_no), 32'(out_tdata[COL_LSB +: LINE_BITS]));
        check_field("last", 32'(want.last), 32'(out_tlast));
        check_field("padding", 32'd0, 32'(out_tdata[OUT_DATA_W-1:OUT_BITS]));
      end
    end
  end

  // Watchdog: a run in which no word moves on either side for too long is hung.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles, %0d tokens still owed", $time,
               quiet_cycles, lexed_tokens.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed script, then random text closed by an
  // end of source, then a wait until every owed token has come out.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    foreach (lex_word[i]) lex_word[i] = '0;
    clear_scan();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[r])
      offer({SCRIPT[r].eos, SCRIPT[r].ch}, SCRIPT[r].typed, SCRIPT[r].tok);

    while (source_text.size() < RANDOM_WORDS) add_lexeme();
    put_end();
    random_phase = 1'b1;
    foreach (source_text[i]) offer(source_text[i], 1'b0, '0);
    random_phase = 1'b0;
    in_tvalid <= 1'b0;

    while (lexed_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
